/* hdl/delayed_note_off_timer_table_core_assert.svh */
// assertion macros shared by the timer table rtl
`ifndef DELAYED_NOTE_OFF_TIMER_TABLE_CORE_ASSERT_SVH
`define DELAYED_NOTE_OFF_TIMER_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DNOT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dnot check failed");

// next-cycle implication, checked out of reset
`define DNOT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dnot check failed");

`endif

/* hdl/dnot_pkg.sv */
package dnot_pkg;

    // most note-off words one tick may emit
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // command codes
    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_OFF   = 1'b1;

    // schedule reply status
    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [6:0]  note;
        logic [6:0]  program_req;
        logic [31:0] wait_ms;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic       kind;
        logic       status;
        logic [6:0] off_note;
        logic [6:0] off_program;
        logic       last;
    } t_out_word;

    // one table entry as held in the slot ram
    typedef struct packed {
        logic [6:0]  note;
        logic [6:0]  program_req;
        logic [31:0] expiry;
    } t_slot;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_REPLY,
        S_SCAN,
        S_CMP,
        S_EMIT,
        S_EMIT_LD
    } t_state;

endpackage

/* hdl/delayed_note_off_timer_table_core.sv */
// Table of SLOTS one-shot note-off timers, worked by a small sequencer around
// one shared 32-bit adder and one slot ram with a registered read port. The
// input side takes one word at a time and is not ready until that word is
// done; a finished result sits in the output register, so the next word can
// be taken while it waits. A schedule word walks the active bits from slot 0
// to the first free one, or to the last slot when the table is full, and then
// sends its reply. A tick word reads and checks every slot through the ram and
// adder, one read and one compare per slot. If anything expired, the slots are
// walked again from slot 0 up to the last expired one, and each expired slot
// is read and emitted. Output stalls hold the reply and emit states. The table
// is empty right after reset; no clearing pass is needed.
`include "delayed_note_off_timer_table_core_assert.svh"

module delayed_note_off_timer_table_core #(
    parameter int SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dnot_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dnot_pkg::t_out_word  o_out_word
);

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW   = $bits(dnot_pkg::t_slot);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [dnot_pkg::CNT_W-1:0] CNT_CAP = dnot_pkg::CNT_W'(dnot_pkg::MAX_RESULTS);

    dnot_pkg::t_state    r_state, n_state;
    dnot_pkg::t_in_word  r_in, n_in;
    logic [IW-1:0]       r_idx, n_idx;
    logic [SLOTS-1:0]    r_act, n_act;
    logic [SLOTS-1:0]    r_hit, n_hit;
    logic [dnot_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                r_full, n_full;
    logic                r_out_valid, n_out_valid;
    dnot_pkg::t_out_word r_out, n_out;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_expired;
    logic [31:0]         w_opb;
    logic [31:0]         w_sum;
    logic                w_ram_we;
    dnot_pkg::t_slot     w_wslot;
    dnot_pkg::t_slot     w_rslot;
    logic [SW-1:0]       w_rdata;
    logic                w_reply_shown;
    logic                w_last_emit;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // slot storage: note, program and expiry per slot
    assign w_wslot.note        = r_in.note;
    assign w_wslot.program_req = r_in.program_req;
    assign w_wslot.expiry      = w_sum;

    dnot_ram #(
        .WIDTH(SW),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_idx),
        .i_wdata(w_wslot),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    assign w_rslot = dnot_pkg::t_slot'(w_rdata);

    // shared adder: now + delay when scheduling, now - expiry when checking
    assign w_opb = (r_in.cmd == dnot_pkg::CMD_SCHEDULE) ? r_in.wait_ms : ~w_rslot.expiry;
    assign w_sum = r_in.now_ms + w_opb + {31'b0, (r_in.cmd == dnot_pkg::CMD_TICK)};

    // slot under check has expired and there is room for one more event
    assign w_expired = r_act[r_idx] && !w_sum[31] && (r_cnt < CNT_CAP);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dnot_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in_word.cmd == dnot_pkg::CMD_SCHEDULE) ?
                              dnot_pkg::S_FIND : dnot_pkg::S_SCAN;
                end
            end
            dnot_pkg::S_FIND: begin
                if (!r_act[r_idx] || (r_idx == LAST_IDX)) begin
                    n_state = dnot_pkg::S_REPLY;
                end
            end
            dnot_pkg::S_REPLY: begin
                if (w_out_free) begin
                    n_state = dnot_pkg::S_IDLE;
                end
            end
            dnot_pkg::S_SCAN: begin
                n_state = dnot_pkg::S_CMP;
            end
            dnot_pkg::S_CMP: begin
                if (r_idx != LAST_IDX) begin
                    n_state = dnot_pkg::S_SCAN;
                end else if (w_expired || (r_cnt != '0)) begin
                    n_state = dnot_pkg::S_EMIT;
                end else begin
                    n_state = dnot_pkg::S_IDLE;
                end
            end
            dnot_pkg::S_EMIT: begin
                if (r_hit[r_idx]) begin
                    n_state = dnot_pkg::S_EMIT_LD;
                end
            end
            dnot_pkg::S_EMIT_LD: begin
                if (w_out_free) begin
                    n_state = (r_cnt == dnot_pkg::CNT_W'(1)) ?
                              dnot_pkg::S_IDLE : dnot_pkg::S_EMIT;
                end
            end
            default: begin
                n_state = dnot_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_in        = r_in;
        n_idx       = r_idx;
        n_act       = r_act;
        n_hit       = r_hit;
        n_cnt       = r_cnt;
        n_full      = r_full;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_ram_we    = 1'b0;
        case (r_state)
            dnot_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_in  = i_in_word;
                    n_idx = '0;
                    n_cnt = '0;
                end
            end
            dnot_pkg::S_FIND: begin
                // store into the first free slot
                if (!r_act[r_idx]) begin
                    w_ram_we     = 1'b1;
                    n_act[r_idx] = 1'b1;
                    n_full       = dnot_pkg::STATUS_STORED;
                end else if (r_idx == LAST_IDX) begin
                    n_full = dnot_pkg::STATUS_FULL;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            dnot_pkg::S_REPLY: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = dnot_pkg::KIND_REPLY;
                    n_out.status      = r_full;
                    n_out.off_note    = '0;
                    n_out.off_program = '0;
                    n_out.last        = 1'b1;
                end
            end
            dnot_pkg::S_SCAN: begin
                // ram read of r_idx in flight
            end
            dnot_pkg::S_CMP: begin
                // mark and free expired slot
                if (w_expired) begin
                    n_hit[r_idx] = 1'b1;
                    n_act[r_idx] = 1'b0;
                    n_cnt        = r_cnt + dnot_pkg::CNT_W'(1);
                end
                n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + IW'(1);
            end
            dnot_pkg::S_EMIT: begin
                if (!r_hit[r_idx]) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            dnot_pkg::S_EMIT_LD: begin
                if (w_out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = dnot_pkg::KIND_OFF;
                    n_out.status      = dnot_pkg::STATUS_STORED;
                    n_out.off_note    = w_rslot.note;
                    n_out.off_program = w_rslot.program_req;
                    n_out.last        = (r_cnt == dnot_pkg::CNT_W'(1));
                    n_hit[r_idx]      = 1'b0;
                    n_cnt             = r_cnt - dnot_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dnot_pkg::S_IDLE;
            r_act       <= '0;
            r_hit       <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_act       <= n_act;
            r_hit       <= n_hit;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_full <= n_full;
        r_out  <= n_out;
    end

    assign o_in_ready  = (r_state == dnot_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // check terms
    assign w_reply_shown = o_out_valid && (o_out_word.kind == dnot_pkg::KIND_REPLY);
    assign w_last_emit   = (r_state == dnot_pkg::S_EMIT_LD) && w_out_free &&
                           (r_cnt == dnot_pkg::CNT_W'(1));

    // checks
    `DNOT_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != dnot_pkg::S_IDLE, !o_in_ready)
    `DNOT_ASSERT_IMP(a_hit_freed, i_clk, i_rst_n, 1'b1, (r_hit & r_act) == '0)
    `DNOT_ASSERT_IMP(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_CAP)
    `DNOT_ASSERT_IMP(a_reply_last, i_clk, i_rst_n, w_reply_shown, o_out_word.last)
    `DNOT_ASSERT_NXT(a_idle_clean, i_clk, i_rst_n, w_last_emit, r_hit == '0)

endmodule

/* hdl/dnot_ram.sv */
module dnot_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOTS      = 8;
    localparam int RAND_WORDS = 200;
    localparam int QUIET_END  = 64;
    localparam int CYCLE_CAP  = 400000;

    // one queued input word, optionally held back until the table is drained
    typedef struct packed {
        logic               hold;
        dnot_pkg::t_in_word w;
    } t_pend;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    dnot_pkg::t_in_word  i_in_word   = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    dnot_pkg::t_out_word o_out_word;

    t_pend               pend_q[$];
    dnot_pkg::t_out_word due_words[$];

    // shadow copy of the timer table
    logic        tbl_active [SLOTS];
    logic [6:0]  tbl_note   [SLOTS];
    logic [6:0]  tbl_prog   [SLOTS];
    logic [31:0] tbl_expiry [SLOTS];

    int n_fail      = 0;
    int n_launched  = 0;
    int n_total     = 1;
    int quiet_cycles = 0;
    int cycle_cnt   = 0;
    int n_stored    = 0;
    int n_full      = 0;
    int n_offs      = 0;
    int n_ticks     = 0;

    logic [1:0]  idle_phase;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    delayed_note_off_timer_table_core #(
        .SLOTS(SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // idle rates move through three phases as words go out
    assign idle_phase = (n_launched * 3 < n_total) ? 2'd0 :
                        (n_launched * 3 < n_total * 2) ? 2'd1 : 2'd2;
    assign send_idle_pct = (idle_phase == 2'd0) ? 19 : (idle_phase == 2'd1) ? 87 : 0;
    assign recv_idle_pct = (idle_phase == 2'd0) ? 87 : (idle_phase == 2'd1) ? 19 : 0;

    // apply one accepted word to the shadow table, queue the words it causes
    task automatic timer_table_apply(input dnot_pkg::t_in_word w);
        dnot_pkg::t_out_word r;
        dnot_pkg::t_out_word held;
        logic                have_held;
        logic                placed;
        logic [31:0]         diff;
        int                  n_ev;
        n_ev = 0;
        have_held = 1'b0;
        placed = 1'b0;
        held = '0;
        if (w.cmd == dnot_pkg::CMD_SCHEDULE) begin
            r = '0;
            r.kind = dnot_pkg::KIND_REPLY;
            r.last = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!tbl_active[i] && !placed) begin
                    tbl_active[i] = 1'b1;
                    tbl_note[i]   = w.note;
                    tbl_prog[i]   = w.program_req;
                    tbl_expiry[i] = w.now_ms + w.wait_ms;
                    placed = 1'b1;
                end
            end
            r.status = placed ? dnot_pkg::STATUS_STORED : dnot_pkg::STATUS_FULL;
            if (placed) n_stored++;
            else n_full++;
            due_words.push_back(r);
        end else begin
            n_ticks++;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_active[i] && n_ev < dnot_pkg::MAX_RESULTS) begin
                    diff = w.now_ms - tbl_expiry[i];
                    if (!diff[31]) begin
                        // the previous event is not the last one, send it on
                        if (have_held) due_words.push_back(held);
                        held = '0;
                        held.kind = dnot_pkg::KIND_OFF;
                        held.off_note = tbl_note[i];
                        held.off_program = tbl_prog[i];
                        have_held = 1'b1;
                        tbl_active[i] = 1'b0;
                        n_ev++;
                        n_offs++;
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                due_words.push_back(held);
            end
        end
    endtask

    task automatic queue_sched(input logic [6:0] note, input logic [6:0] prog,
                               input logic [31:0] delay, input logic [31:0] now,
                               input logic hold);
        t_pend p;
        p.hold = hold;
        p.w.cmd = dnot_pkg::CMD_SCHEDULE;
        p.w.note = note;
        p.w.program_req = prog;
        p.w.wait_ms = delay;
        p.w.now_ms = now;
        pend_q.push_back(p);
    endtask

    // the unused fields of a tick carry noise
    task automatic queue_tick(input logic [31:0] now, input logic hold);
        t_pend p;
        p.hold = hold;
        p.w.cmd = dnot_pkg::CMD_TICK;
        p.w.note = 7'($urandom_range(0, 127));
        p.w.program_req = 7'($urandom_range(0, 127));
        p.w.wait_ms = $urandom;
        p.w.now_ms = now;
        pend_q.push_back(p);
    endtask

    // input driver
    always @(posedge i_clk) begin : driver
        t_pend nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (pend_q.size() != 0 &&
                !(pend_q[0].hold && (i_in_valid || quiet_cycles < 4)) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pend_q.pop_front();
                i_in_word  <= nxt.w;
                i_in_valid <= 1'b1;
                n_launched <= n_launched + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor: check each result word, then predict from each accepted input word
    always @(posedge i_clk) begin : monitor
        dnot_pkg::t_out_word want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (due_words.size() == 0) begin
                    $error("result word with nothing due: %h", o_out_word);
                    n_fail++;
                end else begin
                    want = due_words.pop_front();
                    if (o_out_word.kind !== want.kind) begin
                        $error("kind: expected %0h got %0h", want.kind, o_out_word.kind);
                        n_fail++;
                    end
                    if (o_out_word.status !== want.status) begin
                        $error("status: expected %0h got %0h", want.status,
                               o_out_word.status);
                        n_fail++;
                    end
                    if (o_out_word.off_note !== want.off_note) begin
                        $error("off_note: expected %0h got %0h", want.off_note,
                               o_out_word.off_note);
                        n_fail++;
                    end
                    if (o_out_word.off_program !== want.off_program) begin
                        $error("off_program: expected %0h got %0h", want.off_program,
                               o_out_word.off_program);
                        n_fail++;
                    end
                    if (o_out_word.last !== want.last) begin
                        $error("last: expected %0h got %0h", want.last, o_out_word.last);
                        n_fail++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                timer_table_apply(i_in_word);
                quiet_cycles <= 0;
            end else if (due_words.size() == 0) begin
                quiet_cycles <= (quiet_cycles < 1000) ? quiet_cycles + 1 : quiet_cycles;
            end else begin
                quiet_cycles <= 0;
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    // stimulus and end of run
    initial begin : stim
        logic [31:0] cursor;
        logic [31:0] delay;
        logic [31:0] now;
        int          pick;
        int          dpick;
        logic        hold;

        for (int i = 0; i < SLOTS; i++) begin
            tbl_active[i] = 1'b0;
            tbl_note[i]   = '0;
            tbl_prog[i]   = '0;
            tbl_expiry[i] = '0;
        end

        // directed: empty table, extremes, full table, wrap, equal time
        queue_tick(32'h0000_0000, 1'b0);
        queue_sched(7'd0, 7'd0, 32'd0, 32'hFFFF_FFF0, 1'b0);
        queue_sched(7'd127, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
        queue_sched(7'h55, 7'h2A, 32'h7FFF_FFFF, 32'hFFFF_FFF0, 1'b0);
        queue_sched(7'h2A, 7'h55, 32'h8000_0000, 32'hFFFF_FFF0, 1'b0);
        queue_sched(7'd1, 7'd2, 32'd16, 32'hFFFF_FFF0, 1'b0);
        queue_sched(7'd3, 7'd4, 32'd1, 32'hFFFF_FFF0, 1'b0);
        queue_sched(7'd5, 7'd6, 32'd100, 32'hFFFF_FFF0, 1'b0);
        queue_sched(7'd8, 7'd9, 32'd2, 32'hFFFF_FFF0, 1'b0);
        queue_sched(7'd10, 7'd11, 32'd0, 32'hFFFF_FFF0, 1'b0);
        queue_tick(32'hFFFF_FFEF, 1'b0);
        queue_tick(32'hFFFF_FFF0, 1'b0);
        queue_sched(7'd12, 7'd13, 32'd3, 32'hFFFF_FFF0, 1'b0);
        // two ticks half a wrap apart release every slot
        queue_tick(32'h0000_0000, 1'b0);
        queue_tick(32'h8000_0000, 1'b0);
        // fill all slots due at once, then one tick at its limit of events
        for (int i = 0; i < SLOTS; i++)
            queue_sched(7'(100 + i), 7'(20 + 3 * i), 32'd0, 32'd1000, 1'b0);
        queue_tick(32'd1000, 1'b1);

        // random: a running clock with schedules near it, plus noise
        cursor = 32'hFFFF_FE00 - $urandom_range(0, 255);
        for (int k = 0; k < RAND_WORDS; k++) begin
            hold = (k % 50 == 25);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                dpick = $urandom_range(0, 99);
                if (dpick < 80) delay = $urandom_range(0, 40);
                else if (dpick < 90) delay = $urandom;
                else delay = 32'h7FFF_FFF0 + $urandom_range(0, 31);
                now = ($urandom_range(0, 9) == 0) ? $urandom : cursor;
                queue_sched(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                            delay, now, hold);
            end else if (pick < 97) begin
                cursor = cursor + $urandom_range(0, 15);
                queue_tick(cursor, hold);
            end else begin
                queue_tick($urandom, hold);
            end
            if ($urandom_range(0, 39) == 0) cursor = cursor + $urandom;
        end
        n_total = pend_q.size();

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (pend_q.size() != 0 || i_in_valid || quiet_cycles < QUIET_END)
            @(posedge i_clk);

        $display("covered %0d input words, %0d of them ticks, through three stall mixes",
                 n_total, n_ticks);
        $display("schedules stored %0d, refused on a full table %0d, note-offs %0d",
                 n_stored, n_full, n_offs);
        if (n_fail == 0 && due_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/dnot_pkg.sv
hdl/dnot_ram.sv
hdl/delayed_note_off_timer_table_core.sv
tb/tb_top.sv
